[sv/blr_pkg.sv]
// ----------------------------------------------------------------------------
// blr_pkg
// Shared widths, codes and types for the line rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam int COORD_BITS = 12;              // signed pixel coordinate width
	localparam int CFG_BITS   = 12;              // surface size register width
	localparam int COLOR_BITS = 32;
	localparam int DELTA_BITS = COORD_BITS + 1;  // |dx|, -|dy|
	localparam int ERR_BITS   = COORD_BITS + 2;  // error term, stays within +-1.5*delta

	localparam int IN_FIELDS_BITS  = 4 * COORD_BITS + COLOR_BITS;
	localparam int IN_DATA_BITS    = ((IN_FIELDS_BITS + 7) / 8) * 8;
	localparam int OUT_FIELDS_BITS = 2 * COORD_BITS + COLOR_BITS;
	localparam int OUT_DATA_BITS   = ((OUT_FIELDS_BITS + 7) / 8) * 8;
	localparam int CMP_BITS        = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_TICK  = 1'b1
	} req_type_t;

	typedef enum logic {
		CFG_SURFACE_WIDTH  = 1'b0,
		CFG_SURFACE_HEIGHT = 1'b1
	} cfg_index_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DELTA_BITS-1:0] delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic [COLOR_BITS-1:0]        color_t;
	typedef logic [CFG_BITS-1:0]          cfg_t;

	// One classified request, with line setup already done for starts.
	typedef struct packed {
		req_type_t kind;
		coord_t    x0;
		coord_t    y0;
		coord_t    x1;
		coord_t    y1;
		delta_t    abs_dx;
		delta_t    neg_abs_dy;
		logic      step_x_neg;
		logic      step_y_neg;
		err_t      err_init;
		color_t    color;
	} line_cmd_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic      valid;
		line_cmd_t cmd;
	} cmd_head_t;

endpackage

[sv/blr_front.sv]
// ----------------------------------------------------------------------------
// blr_front
// Request decode and line setup: deltas, step directions, initial error.
// ----------------------------------------------------------------------------
module blr_front import blr_pkg::*; (
	input  logic                    s_tuser,
	input  logic [IN_DATA_BITS-1:0] s_tdata,
	output line_cmd_t               cmd
);

	coord_t x0, y0, x1, y1;
	delta_t dx, dy;
	delta_t abs_dx, neg_abs_dy;

	assign x0 = s_tdata[COORD_BITS-1:0];
	assign y0 = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign x1 = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign y1 = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

	assign dx = delta_t'(x1) - delta_t'(x0);
	assign dy = delta_t'(y1) - delta_t'(y0);

	assign abs_dx     = dx[DELTA_BITS-1] ? -dx : dx;
	assign neg_abs_dy = dy[DELTA_BITS-1] ? dy : -dy;

	always_comb begin
		cmd.kind       = req_type_t'(s_tuser);
		cmd.x0         = x0;
		cmd.y0         = y0;
		cmd.x1         = x1;
		cmd.y1         = y1;
		cmd.abs_dx     = abs_dx;
		cmd.neg_abs_dy = neg_abs_dy;
		cmd.step_x_neg = !(x0 < x1);
		cmd.step_y_neg = !(y0 < y1);
		cmd.err_init   = err_t'(abs_dx) + err_t'(neg_abs_dy);
		cmd.color      = s_tdata[IN_FIELDS_BITS-1:4*COORD_BITS];
	end

endmodule

[sv/blr_fifo.sv]
// ----------------------------------------------------------------------------
// blr_fifo
// Short command queue between request decode and the pixel stepper.
// ----------------------------------------------------------------------------
module blr_fifo import blr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  line_cmd_t push_cmd,
	output logic      full,
	input  logic      pop,
	output cmd_head_t head
);

	line_cmd_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic                     do_push, do_pop;

	assign full      = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	assign do_push = push && !full;
	assign do_pop  = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/blr_back.sv]
// ----------------------------------------------------------------------------
// blr_back
// Bresenham stepper: holds the active line, emits one pixel per tick while a
// line is active, clips against the surface size, drives the output register.
// ----------------------------------------------------------------------------
module blr_back import blr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [CFG_BITS-1:0]      cfg_wdata,
	input  cmd_head_t                head,
	output logic                     pop,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic                     m_tuser,
	output logic                     m_tlast
);

	cfg_t   width_q, height_q;
	coord_t cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	delta_t abs_dx_q, neg_abs_dy_q;
	logic   step_x_neg_q, step_y_neg_q;
	err_t   err_q;
	color_t color_q;
	logic   busy_q;

	logic   out_valid_q;
	coord_t out_x_q, out_y_q;
	color_t out_color_q;
	logic   out_on_q, out_last_q;

	logic   out_free, is_start, emit;
	logic   at_tx, at_ty, want_x, want_y, last, move_x, move_y, on_surface;
	logic signed [ERR_BITS:0] e2;
	err_t   err_next;
	coord_t x_next, y_next;

	assign out_free = !out_valid_q || m_tready;
	assign is_start = (head.cmd.kind == REQ_START);
	// starts and idle ticks never produce a pixel, so they need no output slot
	assign pop  = head.valid && (is_start || !busy_q || out_free);
	assign emit = head.valid && !is_start && busy_q && out_free;

	assign at_tx  = (cur_x_q == tgt_x_q);
	assign at_ty  = (cur_y_q == tgt_y_q);
	assign e2     = {err_q, 1'b0};
	assign want_x = (e2 >= (ERR_BITS+1)'(neg_abs_dy_q));
	assign want_y = (e2 <= (ERR_BITS+1)'(abs_dx_q));

	// e2 is taken before either update; a y step is only tried if x did not end it
	always_comb begin
		last   = 1'b0;
		move_x = 1'b0;
		move_y = 1'b0;
		if (at_tx && at_ty) begin
			last = 1'b1;
		end else begin
			if (want_x) begin
				if (at_tx) begin
					last = 1'b1;
				end else begin
					move_x = 1'b1;
				end
			end
			if (!last && want_y) begin
				if (at_ty) begin
					last = 1'b1;
				end else begin
					move_y = 1'b1;
				end
			end
		end
	end

	assign err_next = err_q + (move_x ? err_t'(neg_abs_dy_q) : '0)
	                        + (move_y ? err_t'(abs_dx_q) : '0);
	assign x_next   = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
	assign y_next   = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;

	assign on_surface = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1]
	                 && (CMP_BITS'($unsigned(cur_x_q)) < CMP_BITS'(width_q))
	                 && (CMP_BITS'($unsigned(cur_y_q)) < CMP_BITS'(height_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SURFACE_WIDTH:  width_q  <= cfg_wdata;
				CFG_SURFACE_HEIGHT: height_q <= cfg_wdata;
			endcase
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			tgt_x_q      <= '0;
			tgt_y_q      <= '0;
			abs_dx_q     <= '0;
			neg_abs_dy_q <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			err_q        <= '0;
			color_q      <= '0;
		end else if (pop && is_start) begin
			busy_q       <= 1'b1;
			cur_x_q      <= head.cmd.x0;
			cur_y_q      <= head.cmd.y0;
			tgt_x_q      <= head.cmd.x1;
			tgt_y_q      <= head.cmd.y1;
			abs_dx_q     <= head.cmd.abs_dx;
			neg_abs_dy_q <= head.cmd.neg_abs_dy;
			step_x_neg_q <= head.cmd.step_x_neg;
			step_y_neg_q <= head.cmd.step_y_neg;
			err_q        <= head.cmd.err_init;
			color_q      <= head.cmd.color;
		end else if (emit) begin
			busy_q <= !last;
			err_q  <= err_next;
			if (move_x) begin
				cur_x_q <= x_next;
			end
			if (move_y) begin
				cur_y_q <= y_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q     <= cur_x_q;
			out_y_q     <= cur_y_q;
			out_color_q <= color_q;
			out_on_q    <= on_surface;
			out_last_q  <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_BITS'({out_color_q, out_y_q, out_x_q});
	assign m_tuser  = out_on_q;
	assign m_tlast  = out_last_q;

endmodule

[sv/bresenham_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// All-octant integer line rasterizer with surface clipping.
// ----------------------------------------------------------------------------
// A start request (s_tuser = 0) loads two signed endpoints and a color and
// replaces any line still being drawn; it produces no output. Each tick
// request (s_tuser = 1) then produces the next pixel of the line, first
// endpoint to second, with the color, an on-surface flag in m_tuser and
// m_tlast on the final pixel. Ticks with no line active produce nothing.
// Throughput is one request per clock while m_tready does not stall the
// output: the stepper does one Bresenham step (one three-input error add
// and two coordinate compares) per cycle. Requests enter a 4-entry queue
// after line setup, so s_tready only drops when the queue is full, i.e.
// when m_tready has been held low long enough to back it up. Surface width
// and height are written through cfg_we; the user must do so only while no
// request is in flight, not enforced by the block; reset values are 640 x 480.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer import blr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration: index 0 surface_width, 1 surface_height
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [CFG_BITS-1:0]      cfg_wdata,
	// request stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // start_x, start_y, end_x, end_y, line_color
	input  logic                     s_tuser,   // req_type
	// pixel stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // pixel_x, pixel_y, pixel_color
	output logic                     m_tuser,   // on_surface
	output logic                     m_tlast    // last_pixel
);

	line_cmd_t front_cmd;
	cmd_head_t head;
	logic      q_full;
	logic      q_pop;

	// decode and setup happen in front of the queue, so the stepper only loads
	blr_front u_front (
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.cmd     (front_cmd)
	);

	assign s_tready = !q_full;

	blr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (head)
	);

	// stepper pops starts and idle ticks freely; busy ticks wait on the output slot
	blr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

[sv/blr_chk.sv]
// ----------------------------------------------------------------------------
// blr_chk
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module blr_chk import blr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic                     m_tuser,
	input  logic                     m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("pixel dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled pixel changed");

	// a pixel flagged on-surface can never have a negative coordinate
	a_on_surface_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[COORD_BITS-1] && !m_tdata[2*COORD_BITS-1])
		else $error("on-surface pixel with negative coordinate");

	// nothing can reach the output at the clock where reset is seen to rise
	a_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind bresenham_line_rasterizer blr_chk u_blr_chk (.*);

[bench/bresenham_line_rasterizer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_test
// Self-checking regression for the line rasterizer.
// ----------------------------------------------------------------------------
// Requests come from a queue that the sequencer fills phase by phase. The driver
// plays them onto the slave stream. Each accepted request runs through a local
// Bresenham stepper that predicts the pixel it causes, if any. The monitor
// compares every pixel on the master stream against the oldest prediction.
// Surface size is rewritten between phases while the engine is drained.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_test;
	import blr_pkg::*;

	localparam int HOLD_OFF     = 12;    // > request-to-pixel latency plus queue
	localparam int STALL_LIMIT  = 5000;  // cycles with no handshake at all
	localparam int IDLE_PERCENT = 6;
	localparam int PHASE_ITEMS  = 175;

	// one request as queued for the driver
	typedef struct {
		req_type_t kind;
		coord_t    x0;
		coord_t    y0;
		coord_t    x1;
		coord_t    y1;
		color_t    color;
	} line_req_t;

	// one predicted pixel
	typedef struct {
		coord_t px;
		coord_t py;
		color_t color;
		logic   on_surface;
		logic   last;
	} pixel_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	logic [0:0]               cfg_index = '0;
	logic [CFG_BITS-1:0]      cfg_wdata = '0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
	logic                     s_tuser   = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tuser;
	logic                     m_tlast;

	bresenham_line_rasterizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	line_req_t request_q[$];   // waiting for the driver
	pixel_t    pixel_q[$];     // predicted, not yet seen on the master side
	line_req_t on_bus;         // request currently offered on s_*
	int        mismatches = 0;
	bit        no_idle    = 1'b0;   // set for one phase: both sides run flat out

	// ------------------------------------------------------------------------
	// Stepper mirror: surface size and line state
	// ------------------------------------------------------------------------
	int     surf_w = 640;
	int     surf_h = 480;
	int     walk_x, walk_y, goal_x, goal_y;
	int     span_x, neg_span_y, err_term;
	bit     x_backward, y_backward;
	color_t ink;
	bit     drawing = 1'b0;

	// Advance the mirror by one accepted request; ticks while drawing emit a pixel.
	function automatic void rasterize(line_req_t r);
		pixel_t p;
		int     e2;
		bit     done;
		int     ax, ay, bx, by;
		ax = r.x0;
		ay = r.y0;
		bx = r.x1;
		by = r.y1;
		if (r.kind == REQ_START) begin
			walk_x     = ax;
			walk_y     = ay;
			goal_x     = bx;
			goal_y     = by;
			span_x     = (bx >= ax) ? bx - ax : ax - bx;
			neg_span_y = (by >= ay) ? ay - by : by - ay;
			x_backward = !(ax < bx);
			y_backward = !(ay < by);
			err_term   = span_x + neg_span_y;
			ink        = r.color;
			drawing    = 1'b1;
			return;
		end
		if (!drawing)
			return;
		p.px         = coord_t'(walk_x);
		p.py         = coord_t'(walk_y);
		p.color      = ink;
		p.on_surface = (walk_x >= 0 && walk_x < surf_w && walk_y >= 0 && walk_y < surf_h);
		done = 1'b0;
		if (walk_x == goal_x && walk_y == goal_y) begin
			done = 1'b1;
		end else begin
			e2 = err_term * 2;
			if (e2 >= neg_span_y) begin
				// x step due but x already at target: line ends here
				if (walk_x == goal_x) begin
					done = 1'b1;
				end else begin
					err_term += neg_span_y;
					walk_x   += x_backward ? -1 : 1;
				end
			end
			if (!done && e2 <= span_x) begin
				if (walk_y == goal_y) begin
					done = 1'b1;
				end else begin
					err_term += span_x;
					walk_y   += y_backward ? -1 : 1;
				end
			end
		end
		p.last = done;
		if (done)
			drawing = 1'b0;
		pixel_q.push_back(p);
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				rasterize(on_bus);
			// hold a request until taken; otherwise maybe offer the next one
			if (!s_tvalid || s_tready) begin
				if (request_q.size() != 0 &&
				    !(!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)) begin
					on_bus   = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= on_bus.kind;
					s_tdata  <= IN_DATA_BITS'({on_bus.color, on_bus.y1, on_bus.x1,
					                           on_bus.y0, on_bus.x0});
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Pixel monitor and backpressure
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : pixel_monitor
		pixel_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || $urandom_range(0, 99) >= IDLE_PERCENT;
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected pixel data=%h", m_tdata));
				end else begin
					want = pixel_q.pop_front();
					if (coord_t'(m_tdata[COORD_BITS-1:0]) !== want.px)
						flag_mismatch($sformatf("pixel_x %0d, want %0d",
						    $signed(m_tdata[COORD_BITS-1:0]), want.px));
					if (coord_t'(m_tdata[2*COORD_BITS-1:COORD_BITS]) !== want.py)
						flag_mismatch($sformatf("pixel_y %0d, want %0d",
						    $signed(m_tdata[2*COORD_BITS-1:COORD_BITS]), want.py));
					if (m_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS] !== want.color)
						flag_mismatch($sformatf("pixel_color %h, want %h",
						    m_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS], want.color));
					if (m_tuser !== want.on_surface)
						flag_mismatch($sformatf("on_surface %b, want %b at (%0d,%0d)",
						    m_tuser, want.on_surface, want.px, want.py));
					if (m_tlast !== want.last)
						flag_mismatch($sformatf("last_pixel %b, want %b at (%0d,%0d)",
						    m_tlast, want.last, want.px, want.py));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any handshake on either side resets the count
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("bresenham_line_rasterizer regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer helpers
	// ------------------------------------------------------------------------
	function automatic line_req_t start_req(int ax, int ay, int bx, int by, color_t c);
		line_req_t r;
		r.kind  = REQ_START;
		r.x0    = coord_t'(ax);
		r.y0    = coord_t'(ay);
		r.x1    = coord_t'(bx);
		r.y1    = coord_t'(by);
		r.color = c;
		return r;
	endfunction

	// tick with junk payload, which the engine ignores
	function automatic line_req_t tick_req();
		line_req_t r;
		r       = start_req($urandom, $urandom, $urandom, $urandom, $urandom);
		r.kind  = REQ_TICK;
		return r;
	endfunction

	function automatic int clamp_coord(int v);
		if (v > 2047)
			return 2047;
		if (v < -2048)
			return -2048;
		return v;
	endfunction

	// full range, around the origin, or around the far surface edge
	function automatic int pick_coord(int edge_at);
		case ($urandom_range(0, 2))
			0: return int'($urandom_range(0, 4095)) - 2048;
			1: return int'($urandom_range(0, 20)) - 10;
			default: return clamp_coord(edge_at + int'($urandom_range(0, 20)) - 10);
		endcase
	endfunction

	// Wait for the pipe to empty, then give in-flight starts/idle ticks time to retire.
	task automatic drain();
		while (request_q.size() != 0 || s_tvalid || pixel_q.size() != 0)
			@(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic set_surface(int w, int h);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SURFACE_WIDTH;
		cfg_wdata <= cfg_t'(w);
		@(posedge clk);
		cfg_index <= CFG_SURFACE_HEIGHT;
		cfg_wdata <= cfg_t'(h);
		@(posedge clk);
		cfg_we    <= 1'b0;
		surf_w = w & 12'hFFF;
		surf_h = h & 12'hFFF;
	endtask

	// Mostly whole lines with random content; some cut short by the next
	// start, some followed by idle ticks, plus pure noise requests.
	task automatic queue_traffic(int budget);
		int added, ax, ay, bx, by, len, ticks;
		added = 0;
		while (added < budget) begin
			if ($urandom_range(0, 99) < 8) begin
				if ($urandom_range(0, 1) == 0) begin
					request_q.push_back(tick_req());
				end else begin
					request_q.push_back(start_req($urandom, $urandom, $urandom,
					                              $urandom, $urandom));
					added++;
				end
			end else begin
				ax = pick_coord(surf_w);
				ay = pick_coord(surf_h);
				if ($urandom_range(0, 9) == 0) begin
					bx = int'($urandom_range(0, 4095)) - 2048;
					by = int'($urandom_range(0, 4095)) - 2048;
				end else begin
					bx = clamp_coord(ax + int'($urandom_range(0, 16)) - 8);
					by = clamp_coord(ay + int'($urandom_range(0, 16)) - 8);
				end
				request_q.push_back(start_req(ax, ay, bx, by, $urandom));
				len = (bx > ax ? bx - ax : ax - bx);
				if ((by > ay ? by - ay : ay - by) > len)
					len = (by > ay ? by - ay : ay - by);
				len++;
				if (len > 40)
					ticks = $urandom_range(0, 40);       // long line, always replaced
				else if ($urandom_range(0, 3) == 0)
					ticks = $urandom_range(0, len);      // possibly cut short
				else
					ticks = len + $urandom_range(0, 2);  // full line, maybe idle ticks
				repeat (ticks) request_q.push_back(tick_req());
				added += 1 + ((ticks < len) ? ticks : len);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	initial begin
		int widths[8]  = '{1, 4095, 0, 640, 2047, 0, 0, 640};
		int heights[8] = '{1, 4095, 480, 0, 2047, 0, 0, 480};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at the reset surface size
		request_q.push_back(tick_req());                        // idle tick
		request_q.push_back(start_req(5, 5, 5, 5, 32'h0000_00A5));
		request_q.push_back(tick_req());                        // single pixel, last
		request_q.push_back(tick_req());                        // idle again
		request_q.push_back(start_req(-2048, -2048, 2047, 2047, 32'hFFFF_FFFF));
		request_q.push_back(tick_req());
		request_q.push_back(tick_req());
		// replaces the line above mid-flight
		request_q.push_back(start_req(2047, -2048, -2048, 2047, 32'h8000_0001));
		request_q.push_back(tick_req());
		// crosses the bottom-right surface corner
		request_q.push_back(start_req(639, 479, 641, 481, 32'h1234_5678));
		repeat (3) request_q.push_back(tick_req());
		// steep, both steps negative
		request_q.push_back(start_req(0, 2, -1, -1, 32'h0));
		repeat (4) request_q.push_back(tick_req());
		// shallow, off the top-left edge
		request_q.push_back(start_req(-1, 0, 2, -1, 32'h5A5A_A5A5));
		repeat (5) request_q.push_back(tick_req());
		drain();

		// random phases over a spread of surface sizes
		for (int ph = 0; ph < 8; ph++) begin
			if (widths[ph] == 0 && heights[ph] == 0)
				set_surface($urandom_range(1, 2047), $urandom_range(1, 2047));
			else
				set_surface(widths[ph], heights[ph]);
			no_idle = (ph == 4);
			queue_traffic(PHASE_ITEMS);
			drain();
		end

		if (pixel_q.size() != 0)
			flag_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));
		if (mismatches == 0)
			$display("bresenham_line_rasterizer regression: pass");
		else
			$display("bresenham_line_rasterizer regression: fail");
		$finish;
	end

endmodule

[files.f]
sv/blr_pkg.sv
sv/blr_front.sv
sv/blr_fifo.sv
sv/blr_back.sv
sv/bresenham_line_rasterizer.sv
sv/blr_chk.sv
bench/bresenham_line_rasterizer_test.sv
